// ===== src/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

    localparam int unsigned LEN_W   = 6;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned START_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_SCAN    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // Per-cycle control broadcast to every cell of the row.
    typedef struct packed {
        logic scan;
        logic rotate;
        logic wr;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== src/wbps_cell.sv =====
// One scanner cell: a window byte, a pattern ring entry and its compare.
`default_nettype none
module wbps_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned AW  = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wbps_pkg::t_cell_ctl          i_ctl,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [wbps_pkg::BYTE_W-1:0]  i_pat_byte,
    input  logic                         i_pat_care,
    input  logic [wbps_pkg::LEN_W-1:0]   i_len,
    input  logic [wbps_pkg::BYTE_W-1:0]  i_win_in,
    input  logic [wbps_pkg::BYTE_W-1:0]  i_ring_byte_in,
    input  logic                         i_ring_care_in,
    output logic [wbps_pkg::BYTE_W-1:0]  o_win,
    output logic [wbps_pkg::BYTE_W-1:0]  o_ring_byte,
    output logic                         o_ring_care,
    output logic                         o_hit
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] n_win;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;
    logic              r_care;
    logic              n_care;
    logic              sel;
    logic              in_use;

    assign sel    = i_ctl.wr && (i_wr_addr == AW'(IDX));
    // position takes part only below the pattern length
    assign in_use = {{(32-LEN_W){1'b0}}, i_len} > 32'(IDX);

    always_comb begin
        n_win  = i_ctl.scan ? i_win_in : r_win;
        n_byte = r_byte;
        n_care = r_care;
        if (i_ctl.rotate) begin
            n_byte = i_ring_byte_in;
            n_care = i_ring_care_in;
        end else if (sel) begin
            n_byte = i_pat_byte;
            n_care = i_pat_care;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_byte <= n_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_care <= 1'b0;
        end else begin
            r_care <= n_care;
        end
    end

    // compare against the byte entering this window position
    assign o_hit       = !in_use || !r_care || (r_byte == i_win_in);
    assign o_win       = r_win;
    assign o_ring_byte = r_byte;
    assign o_ring_care = r_care;

endmodule
`default_nettype wire

// ===== src/wbps_out.sv =====
// Two-word output queue: result register plus skid register.
`default_nettype none
module wbps_out #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic         o_full
);
    import wbps_pkg::*;

    logic         r_out_v;
    logic         n_out_v;
    logic [W-1:0] r_out;
    logic [W-1:0] n_out;
    logic         r_skid_v;
    logic         n_skid_v;
    logic [W-1:0] r_skid;
    logic [W-1:0] n_skid;
    logic         pop;

    assign pop = r_out_v && i_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = i_push;
                n_skid   = i_data;
            end else begin
                n_out_v = i_push;
                n_out   = i_data;
            end
        end else if (!r_out_v) begin
            n_out_v = i_push;
            n_out   = i_data;
        end else if (i_push) begin
            n_skid_v = 1'b1;
            n_skid   = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign o_full  = r_skid_v;

endmodule
`default_nettype wire

// ===== src/wildcard_byte_pattern_scan.sv =====
// Top level: wildcard byte pattern scanner built as a row of cells.
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_op, i_pattern_index, i_pattern_byte,
//                                                     i_pattern_care, i_code_byte
//  out       source     o_out_valid / i_out_ready     o_match_start
//  cfg       sink       i_cfg_valid / o_cfg_ready     i_cfg_pattern_length
//
// One word per cycle while o_in_ready is high; a match word is registered in the output
// register, or in the skid register while that one holds a word. All window positions are
// compared in parallel, one cell each. The pattern sits in a ring across the cells; after a
// length write the ring rotates one cell per cycle until aligned, with the input held off.
// A two-word output queue lets scanning go on while a match waits.
// Reset is synchronous: counters, care bits, length and queue flags clear.
`default_nettype none
module wildcard_byte_pattern_scan #(
    parameter int unsigned MAX_PATTERN   = 32,
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wbps_pkg::OP_W-1:0]     i_op,
    input  logic [wbps_pkg::IDX_W-1:0]    i_pattern_index,
    input  logic [wbps_pkg::BYTE_W-1:0]   i_pattern_byte,
    input  logic                          i_pattern_care,
    input  logic [wbps_pkg::BYTE_W-1:0]   i_code_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wbps_pkg::START_W-1:0]  o_match_start,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wbps_pkg::LEN_W-1:0]    i_cfg_pattern_length
);
    import wbps_pkg::*;

    localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned DW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned SW = (PB > START_W) ? PB : START_W;

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [AW-1:0]     r_off;
    logic [AW-1:0]     n_off;
    logic [AW-1:0]     off_inc;
    logic [PB-1:0]     r_seen;
    logic [PB-1:0]     n_seen;
    logic [PB-1:0]     seen_inc;
    logic [PB-1:0]     len_pb;
    logic [PB-1:0]     start_pb;
    logic [SW-1:0]     start_x;
    logic [31:0]       len32;
    logic [31:0]       off32;
    logic [DW-1:0]     wr_diff;
    logic [AW-1:0]     wr_addr;
    logic              idx_ok;
    logic              len_ok;
    logic              aligned;
    logic              accept;
    logic              cfg_acc;
    logic              q_full;
    logic              push;
    logic              enough;
    t_cell_ctl         ctl;

    logic [BYTE_W-1:0]      win      [MAX_PATTERN];
    logic [BYTE_W-1:0]      ring_b   [MAX_PATTERN];
    logic                   ring_c   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;

    assign len32   = {{(32-LEN_W){1'b0}}, r_len};
    assign off32   = {{(32-AW){1'b0}}, r_off};
    assign len_ok  = (r_len != '0) && (len32 <= 32'(MAX_PATTERN));
    // ring cell w holds pattern position (off - w) mod MAX_PATTERN
    assign aligned = !len_ok || (off32 == len32 - 32'd1);
    assign off_inc = (r_off == AW'(MAX_PATTERN - 1)) ? '0 : r_off + AW'(1);

    assign o_in_ready  = aligned && !q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign idx_ok  = {{(32-IDX_W){1'b0}}, i_pattern_index} < 32'(MAX_PATTERN);
    assign wr_diff = DW'(r_off) - DW'(i_pattern_index);
    assign wr_addr = wr_diff[DW-1] ? AW'(wr_diff + DW'(MAX_PATTERN)) : AW'(wr_diff);

    always_comb begin
        ctl.scan   = 1'b0;
        ctl.wr     = 1'b0;
        ctl.rotate = !aligned;
        if (accept) begin
            unique case (i_op)
                OP_WRITE: ctl.wr   = idx_ok;
                OP_SCAN:  ctl.scan = 1'b1;
                default:  ;
            endcase
        end
    end

    assign seen_inc = (&r_seen) ? r_seen : r_seen + PB'(1);
    assign len_pb   = {{(PB-LEN_W){1'b0}}, r_len};
    assign enough   = seen_inc >= len_pb;
    assign start_pb = seen_inc - len_pb;
    assign start_x  = SW'(start_pb);
    assign push     = ctl.scan && len_ok && enough && (&hits);

    always_comb begin
        n_len  = cfg_acc ? i_cfg_pattern_length : r_len;
        n_off  = aligned ? r_off : off_inc;
        n_seen = r_seen;
        if (ctl.scan) begin
            n_seen = seen_inc;
        end else if (accept && (i_op == OP_RESTART)) begin
            n_seen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_off  <= '0;
            r_seen <= '0;
        end else begin
            r_len  <= n_len;
            r_off  <= n_off;
            r_seen <= n_seen;
        end
    end

    for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_cell
        logic [BYTE_W-1:0] win_in;
        logic [BYTE_W-1:0] rb_in;
        logic              rc_in;

        if (w == 0) begin : g_head
            assign win_in = i_code_byte;
            assign rb_in  = ring_b[MAX_PATTERN-1];
            assign rc_in  = ring_c[MAX_PATTERN-1];
        end else begin : g_body
            assign win_in = win[w-1];
            assign rb_in  = ring_b[w-1];
            assign rc_in  = ring_c[w-1];
        end

        wbps_cell #(
            .IDX (w),
            .AW  (AW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_wr_addr      (wr_addr),
            .i_pat_byte     (i_pattern_byte),
            .i_pat_care     (i_pattern_care),
            .i_len          (r_len),
            .i_win_in       (win_in),
            .i_ring_byte_in (rb_in),
            .i_ring_care_in (rc_in),
            .o_win          (win[w]),
            .o_ring_byte    (ring_b[w]),
            .o_ring_care    (ring_c[w]),
            .o_hit          (hits[w])
        );
    end

    wbps_out #(
        .W (START_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (start_x[START_W-1:0]),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_match_start),
        .o_full  (q_full)
    );

    // a scanned byte always leaves a nonzero count
    a_seen_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.scan |=> (r_seen != '0))
        else $error("byte count zero after scan");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_RESTART)) |=> (r_seen == '0))
        else $error("restart did not clear count");

    // ring advances one cell per cycle while misaligned
    a_ring_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !aligned |=> (r_off == (($past(r_off) == AW'(MAX_PATTERN - 1)) ? '0
                                : $past(r_off) + AW'(1))))
        else $error("pattern ring failed to advance");

    // nothing is written into the ring while it rotates
    a_no_write_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.rotate |-> !ctl.wr && !ctl.scan)
        else $error("item taken during ring rotation");

endmodule
`default_nettype wire
